>>> rtl/sfcp_pkg.sv
// Shared types and constants of the sensor frame checksum parser.
package sfcp_pkg;

  localparam int unsigned PosW = 4;
  localparam int unsigned ByteW = 8;
  localparam int unsigned WordW = 16;

  localparam logic [ByteW-1:0] HeaderMark = 8'hFF;

  // Byte positions inside a nine-byte frame.
  localparam logic [PosW-1:0] PosIdle   = 4'd0;
  localparam logic [PosW-1:0] PosFirst  = 4'd1;
  localparam logic [PosW-1:0] PosId     = 4'd1;
  localparam logic [PosW-1:0] PosUnit   = 4'd2;
  localparam logic [PosW-1:0] PosConcHi = 4'd4;
  localparam logic [PosW-1:0] PosConcLo = 4'd5;
  localparam logic [PosW-1:0] PosFsHi   = 4'd6;
  localparam logic [PosW-1:0] PosFsLo   = 4'd7;
  localparam logic [PosW-1:0] PosCheck  = 4'd8;

  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StBadHeader = 2'd1,
    StBadSum    = 2'd2
  } status_e;

  typedef struct packed {
    logic [ByteW-1:0] sensor_id;
    logic [ByteW-1:0] unit_code;
    logic [WordW-1:0] concentration;
    logic [WordW-1:0] full_range;
  } fields_t;

  typedef struct packed {
    fields_t          fields;
    logic [ByteW-1:0] checksum;
  } record_t;

endpackage

>>> rtl/sensor_frame_checksum_parser.sv
// Top level of the nine-byte sensor frame parser with negated-sum checksum.
//
// Input channel: one frame byte per request on data_byte_i, with frame_start_i
// marking byte 0 of a frame. A request is taken on a rising edge with
// in_valid_i high and in_stall_o low. Bytes outside a frame are dropped, and
// a start mark inside an open frame restarts it without a result.
// Output channel: one request per completed frame, taken when out_valid_o is
// high and out_stall_i low. status_o tells whether the frame was accepted or
// why it was rejected; the record outputs always show the last accepted frame.
// Throughput is one byte per cycle while in_stall_o is low. A byte passes an input
// register and then the position, sum and capture logic, and the result of the
// request that carried the checksum byte is registered in the output register.
// A single output register holds a finished result. While it waits under
// out_stall_i, bytes keep flowing until a checksum byte reaches the decision
// stage; only then is in_stall_o raised.
// Reset clears the byte position, the output valid and the held record, so
// record_valid_o and all record fields read zero until a frame is accepted.
module sensor_frame_checksum_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        frame_start_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic        record_valid_o,
  output logic [7:0]  sensor_id_o,
  output logic [7:0]  unit_code_o,
  output logic [15:0] concentration_o,
  output logic [15:0] full_range_o,
  output logic [7:0]  frame_checksum_o
);

  logic                          s_valid_q;
  logic [sfcp_pkg::ByteW-1:0]    s_byte_q;
  logic                          s_start_q;

  logic [sfcp_pkg::PosW-1:0]     pos_q, pos_d;
  logic [sfcp_pkg::ByteW-1:0]    sum_q, sum_d;
  logic                          hdr_q, hdr_d;
  sfcp_pkg::fields_t             pend_q, pend_d;
  sfcp_pkg::record_t             held_q, held_d;
  logic                          held_valid_q, held_valid_d;

  logic                          out_valid_q, out_valid_d;
  sfcp_pkg::status_e             status_q, status_d;

  logic                          is_check;
  logic                          blocked;
  logic                          fire;
  logic [sfcp_pkg::ByteW-1:0]    expect_sum;

  // The stage may only finish a frame when the output register is free or its result is taken.
  assign is_check   = s_valid_q && !s_start_q && (pos_q == sfcp_pkg::PosCheck);
  assign blocked    = is_check && out_valid_q && out_stall_i;
  assign in_stall_o = blocked;
  assign fire       = s_valid_q && !blocked;
  assign expect_sum = sfcp_pkg::ByteW'(~sum_q + 8'd1);

  always_comb begin
    pos_d        = pos_q;
    sum_d        = sum_q;
    hdr_d        = hdr_q;
    pend_d       = pend_q;
    held_d       = held_q;
    held_valid_d = held_valid_q;
    status_d     = status_q;
    out_valid_d  = out_valid_q && out_stall_i;
    if (fire) begin
      if (s_start_q) begin
        hdr_d  = (s_byte_q == sfcp_pkg::HeaderMark);
        sum_d  = '0;
        pend_d = '0;
        pos_d  = sfcp_pkg::PosFirst;
      end else if (pos_q == sfcp_pkg::PosIdle || pos_q > sfcp_pkg::PosCheck) begin
        pos_d = sfcp_pkg::PosIdle;
      end else if (pos_q < sfcp_pkg::PosCheck) begin
        sum_d = sum_q + s_byte_q;
        pos_d = pos_q + 4'd1;
        unique case (pos_q)
          sfcp_pkg::PosId:     pend_d.sensor_id           = s_byte_q;
          sfcp_pkg::PosUnit:   pend_d.unit_code           = s_byte_q;
          sfcp_pkg::PosConcHi: pend_d.concentration[15:8] = s_byte_q;
          sfcp_pkg::PosConcLo: pend_d.concentration[7:0]  = s_byte_q;
          sfcp_pkg::PosFsHi:   pend_d.full_range[15:8]    = s_byte_q;
          sfcp_pkg::PosFsLo:   pend_d.full_range[7:0]     = s_byte_q;
          default: ;
        endcase
      end else begin
        out_valid_d = 1'b1;
        pos_d       = sfcp_pkg::PosIdle;
        if (!hdr_q) begin
          status_d = sfcp_pkg::StBadHeader;
        end else if (expect_sum != s_byte_q) begin
          status_d = sfcp_pkg::StBadSum;
        end else begin
          status_d        = sfcp_pkg::StOk;
          held_d.fields   = pend_q;
          held_d.checksum = s_byte_q;
          held_valid_d    = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q    <= 1'b0;
      pos_q        <= sfcp_pkg::PosIdle;
      sum_q        <= '0;
      hdr_q        <= 1'b0;
      held_q       <= '0;
      held_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      status_q     <= sfcp_pkg::StOk;
    end else begin
      if (!blocked) begin
        s_valid_q <= in_valid_i;
      end
      pos_q        <= pos_d;
      sum_q        <= sum_d;
      hdr_q        <= hdr_d;
      held_q       <= held_d;
      held_valid_q <= held_valid_d;
      out_valid_q  <= out_valid_d;
      status_q     <= status_d;
    end
  end

  // Payload registers carry no reset; pending fields are cleared at each start.
  always_ff @(posedge clk_i) begin
    if (!blocked && in_valid_i) begin
      s_byte_q  <= data_byte_i;
      s_start_q <= frame_start_i;
    end
    pend_q <= pend_d;
  end

  // The held record changes only when a result enters the output register,
  // so it can drive the record outputs directly.
  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign record_valid_o   = held_valid_q;
  assign sensor_id_o      = held_q.fields.sensor_id;
  assign unit_code_o      = held_q.fields.unit_code;
  assign concentration_o  = held_q.fields.concentration;
  assign full_range_o     = held_q.fields.full_range;
  assign frame_checksum_o = held_q.checksum;

endmodule

>>> rtl/sfcp_checker.sv
// Port-level checker of the sensor frame parser and its bind statement.
module sfcp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [7:0]  data_byte_i,
  input logic        frame_start_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  status_o,
  input logic        record_valid_o,
  input logic [7:0]  sensor_id_o,
  input logic [7:0]  unit_code_o,
  input logic [15:0] concentration_o,
  input logic [15:0] full_range_o,
  input logic [7:0]  frame_checksum_o
);

  // Input is held back only while a finished result waits downstream.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a blocked result");

  // A stalled input request keeps its byte and start mark.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_stall_o) |=> (in_valid_i && $stable(data_byte_i)
      && $stable(frame_start_i)))
    else $error("stalled input request changed");

  // An accepted frame always leaves a valid record.
  a_ok_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == sfcp_pkg::StOk) |-> record_valid_o)
    else $error("accepted frame without a valid record");

  // Once set, the record stays valid until reset.
  a_record_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    record_valid_o |=> record_valid_o)
    else $error("record valid dropped");

  // The record does not change under a waiting result.
  a_record_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> ($stable(sensor_id_o) && $stable(unit_code_o)
      && $stable(concentration_o) && $stable(full_range_o)
      && $stable(frame_checksum_o)))
    else $error("record changed while result stalled");

endmodule

bind sensor_frame_checksum_parser sfcp_checker u_sfcp_checker (.*);

>>> tb/sfcp_frame_checker.sv
// Checker that predicts the frame results of the sensor frame parser and compares them.
`timescale 1ns / 1ps
module sfcp_frame_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  data_byte_i,
  input  logic        frame_start_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  status_i,
  input  logic        record_valid_i,
  input  logic [7:0]  sensor_id_i,
  input  logic [7:0]  unit_code_i,
  input  logic [15:0] concentration_i,
  input  logic [15:0] full_range_i,
  input  logic [7:0]  frame_checksum_i,
  output int          waiting_o,
  output int          mismatches_o,
  output int          ok_frames_o,
  output int          bad_header_o,
  output int          bad_sum_o
);

  typedef struct packed {
    sfcp_pkg::status_e status;
    logic              rec_valid;
    sfcp_pkg::record_t rec;
  } frame_outcome_t;

  frame_outcome_t outcome_q[$];

  // Shadow of the parser state.
  logic [sfcp_pkg::PosW-1:0]  pos;
  logic [sfcp_pkg::ByteW-1:0] sum;
  logic                       hdr_ok;
  sfcp_pkg::fields_t          captured;
  sfcp_pkg::record_t          held;
  logic                       held_ok;

  int errors;
  int n_ok;
  int n_bad_hdr;
  int n_bad_sum;

  task automatic advance_frame(input logic [7:0] b, input logic start);
    frame_outcome_t res;
    logic [7:0]     want_sum;
    if (start) begin
      hdr_ok   = (b == sfcp_pkg::HeaderMark);
      sum      = '0;
      captured = '0;
      pos      = sfcp_pkg::PosFirst;
    end else if (pos == sfcp_pkg::PosIdle || pos > sfcp_pkg::PosCheck) begin
      pos = sfcp_pkg::PosIdle;
    end else if (pos != sfcp_pkg::PosCheck) begin
      sum = sum + b;
      case (pos)
        sfcp_pkg::PosId:     captured.sensor_id = b;
        sfcp_pkg::PosUnit:   captured.unit_code = b;
        sfcp_pkg::PosConcHi: captured.concentration[15:8] = b;
        sfcp_pkg::PosConcLo: captured.concentration[7:0] = b;
        sfcp_pkg::PosFsHi:   captured.full_range[15:8] = b;
        sfcp_pkg::PosFsLo:   captured.full_range[7:0] = b;
        default:   ;
      endcase
      pos = pos + 1'b1;
    end else begin
      want_sum = 8'h00 - sum;
      // A bad header byte is reported even when the checksum is wrong too.
      if (!hdr_ok) begin
        res.status = sfcp_pkg::StBadHeader;
        n_bad_hdr++;
      end else if (want_sum != b) begin
        res.status = sfcp_pkg::StBadSum;
        n_bad_sum++;
      end else begin
        res.status      = sfcp_pkg::StOk;
        held.fields     = captured;
        held.checksum   = b;
        held_ok         = 1'b1;
        n_ok++;
      end
      res.rec_valid = held_ok;
      res.rec       = held;
      outcome_q.push_back(res);
      pos = sfcp_pkg::PosIdle;
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= 10) begin
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
    end
  endtask

  task automatic check_outcome();
    frame_outcome_t want;
    if (outcome_q.size() == 0) begin
      errors++;
      if (errors <= 10) begin
        $display("%0t: result with none expected, status %h", $time, status_i);
      end
    end else begin
      want = outcome_q.pop_front();
      check_field("status", 16'(want.status), 16'(status_i));
      check_field("record_valid", 16'(want.rec_valid), 16'(record_valid_i));
      check_field("sensor_id", 16'(want.rec.fields.sensor_id), 16'(sensor_id_i));
      check_field("unit_code", 16'(want.rec.fields.unit_code), 16'(unit_code_i));
      check_field("concentration", want.rec.fields.concentration, concentration_i);
      check_field("full_range", want.rec.fields.full_range, full_range_i);
      check_field("frame_checksum", 16'(want.rec.checksum), 16'(frame_checksum_i));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos       = sfcp_pkg::PosIdle;
      sum       = '0;
      hdr_ok    = 1'b0;
      captured  = '0;
      held      = '0;
      held_ok   = 1'b0;
      errors    = 0;
      n_ok      = 0;
      n_bad_hdr = 0;
      n_bad_sum = 0;
      outcome_q.delete();
      waiting_o    <= 0;
      mismatches_o <= 0;
      ok_frames_o  <= 0;
      bad_header_o <= 0;
      bad_sum_o    <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        advance_frame(data_byte_i, frame_start_i);
      end
      if (out_valid_i && !out_stall_i) begin
        check_outcome();
      end
      // Counts are published after the edge so readers never race the update.
      waiting_o    <= outcome_q.size();
      mismatches_o <= errors;
      ok_frames_o  <= n_ok;
      bad_header_o <= n_bad_hdr;
      bad_sum_o    <= n_bad_sum;
    end
  end

endmodule

>>> tb/tb_sensor_frame_checksum_parser.sv
// Testbench top for the sensor frame parser: byte stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps
module tb_sensor_frame_checksum_parser;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       drain;
  } byte_req_t;

  localparam int unsigned TargetItems  = 1750;
  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned IdlePct      = 17;
  localparam int unsigned QuietFrom    = 600;
  localparam int unsigned QuietTo      = 1100;
  localparam int unsigned HoldAt       = 1400;
  localparam int unsigned HoldLen      = 150;
  localparam int unsigned DrainEvery   = 40;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        frame_start = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic        record_valid;
  logic [7:0]  sensor_id;
  logic [7:0]  unit_code;
  logic [15:0] concentration;
  logic [15:0] full_range;
  logic [7:0]  frame_checksum;

  int waiting;
  int mismatches;
  int ok_frames;
  int bad_header;
  int bad_sum;
  int cycle = 0;

  byte_req_t req_q[$];

  sensor_frame_checksum_parser dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .data_byte_i     (data_byte),
    .frame_start_i   (frame_start),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .status_o        (status),
    .record_valid_o  (record_valid),
    .sensor_id_o     (sensor_id),
    .unit_code_o     (unit_code),
    .concentration_o (concentration),
    .full_range_o    (full_range),
    .frame_checksum_o(frame_checksum)
  );

  sfcp_frame_checker checker_i (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .data_byte_i     (data_byte),
    .frame_start_i   (frame_start),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .status_i        (status),
    .record_valid_i  (record_valid),
    .sensor_id_i     (sensor_id),
    .unit_code_i     (unit_code),
    .concentration_i (concentration),
    .full_range_i    (full_range),
    .frame_checksum_i(frame_checksum),
    .waiting_o       (waiting),
    .mismatches_o    (mismatches),
    .ok_frames_o     (ok_frames),
    .bad_header_o    (bad_header),
    .bad_sum_o       (bad_sum)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle == CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle, waiting);
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] negated_sum(input logic [55:0] body);
    logic [7:0]  s;
    int unsigned k;
    s = '0;
    for (k = 0; k < 7; k++) begin
      s = s + body[8*k +: 8];
    end
    return 8'h00 - s;
  endfunction

  function automatic bit quiet_now();
    return cycle >= QuietFrom && cycle < QuietTo;
  endfunction

  task automatic queue_stray(input logic [7:0] b);
    byte_req_t r;
    r.data  = b;
    r.start = 1'b0;
    r.drain = 1'b0;
    req_q.push_back(r);
  endtask

  // Queues the first len bytes of a frame; body holds bytes 1 to 7, byte 1 on top.
  task automatic queue_frame(input logic [7:0] hdr, input logic [55:0] body,
                             input logic [7:0] cks, input int unsigned len,
                             input bit drain);
    byte_req_t   r;
    int unsigned i;
    r.data  = hdr;
    r.start = 1'b1;
    r.drain = drain;
    req_q.push_back(r);
    r.start = 1'b0;
    r.drain = 1'b0;
    for (i = 1; i < len; i++) begin
      r.data = (i == 8) ? cks : body[8*(7-i) +: 8];
      req_q.push_back(r);
    end
  endtask

  // Receiver: random stalls, a quiet stretch, and one long hold-off.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (cycle == HoldAt) hold_left = HoldLen;
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (quiet_now()) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < IdlePct);
      end
    end
  end

  initial begin
    int unsigned counted;
    int unsigned frames;
    int unsigned kind;
    int unsigned len;
    int unsigned idx;
    int unsigned drained_idx;
    int unsigned k;
    logic [55:0] body;
    logic [7:0]  hdr;
    logic [7:0]  cks;
    bit          offering;
    bit          drain_armed;

    // A byte with no open frame is dropped.
    queue_stray(8'h5A);
    // Header and checksum both wrong before any accepted frame.
    queue_frame(8'h00, {7{8'hFF}}, 8'h00, 9, 1'b0);
    // Good frame with every field at its maximum.
    queue_frame(sfcp_pkg::HeaderMark, {7{8'hFF}}, negated_sum({7{8'hFF}}), 9, 1'b0);
    // A start mark inside an open frame drops the partial frame.
    queue_frame(sfcp_pkg::HeaderMark, {7{8'hA5}}, 8'h00, 3, 1'b0);
    // Checksum mismatch with zero fields: the held record must stay.
    queue_frame(sfcp_pkg::HeaderMark, 56'h0, 8'hFF, 9, 1'b0);
    // A byte right after byte 8 is outside any frame.
    queue_stray(8'hFF);
    counted = 32;

    frames = 0;
    while (counted < TargetItems) begin
      kind = $urandom_range(0, 99);
      for (k = 0; k < 7; k++) body[8*k +: 8] = pick_byte();
      hdr = sfcp_pkg::HeaderMark;
      cks = negated_sum(body);
      len = 9;
      if (kind < 10) begin
        cks = cks + 8'($urandom_range(1, 255));
      end else if (kind < 18) begin
        hdr = 8'($urandom_range(0, 254));
        if (kind[0]) cks = cks + 8'($urandom_range(1, 255));
      end else if (kind < 25) begin
        len = $urandom_range(1, 8);
      end
      frames++;
      queue_frame(hdr, body, cks, len, (frames % DrainEvery) == 0);
      counted += len;
      if (kind >= 95) begin
        repeat ($urandom_range(1, 3)) queue_stray(pick_byte());
      end
    end

    // Sender: one request per edge at most; a stalled request is held as is.
    idx         = 0;
    drained_idx = 32'hFFFF_FFFF;
    offering    = 1'b0;
    drain_armed = 1'b0;
    wait (rst_n);
    while (idx < req_q.size() || offering) begin
      @(posedge clk);
      if (offering && !in_stall) begin
        idx++;
        offering = 1'b0;
      end
      if (!offering) begin
        if (idx >= req_q.size()) begin
          in_valid <= 1'b0;
        end else if (req_q[idx].drain && drained_idx != idx) begin
          // The pending count is registered and lags, so it is read only once armed.
          if (drain_armed && waiting == 0) begin
            drained_idx = idx;
            drain_armed = 1'b0;
          end else begin
            drain_armed = 1'b1;
          end
          in_valid <= 1'b0;
        end else if (!quiet_now() && $urandom_range(0, 99) < IdlePct) begin
          in_valid <= 1'b0;
        end else begin
          in_valid    <= 1'b1;
          data_byte   <= req_q[idx].data;
          frame_start <= req_q[idx].start;
          offering    = 1'b1;
        end
      end
    end

    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);

    $display("Sent %0d bytes in %0d cycles; checked %0d frame results", req_q.size(),
             cycle, ok_frames + bad_header + bad_sum);
    $display("Outcomes: %0d accepted, %0d bad header, %0d bad checksum; %0d mismatches",
             ok_frames, bad_header, bad_sum, mismatches);
    if (mismatches == 0 && waiting == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
